// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge; off while reset is low.
`define MES_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies a property in the same cycle.
`define MES_ASSERT_IMP(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ----- hdl/mes_pkg.sv -----
// Types and constants shared by the MIDI event sequencer files.
package mes_pkg;

    localparam int DEF_SLOTS       = 16;
    localparam int DEF_EVENT_DEPTH = 4096;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 12;
    localparam int DELTA_W  = 28;
    localparam int BYTE_W   = 8;
    localparam int TIME_W   = 40;
    localparam int TPB_W    = 15;
    localparam int COUNT_W  = 13;
    localparam int POS_W    = 40;
    localparam int FRAC_W   = 16;
    localparam int LIMIT_W  = TIME_W + TPB_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [TPB_W-1:0]  TPB_RESET  = TPB_W'(96);
    localparam logic [BYTE_W-1:0] META_MASK  = 8'hF0;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_QUERY   = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_BEAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_COUNT    = 2'd1;

    typedef struct packed {
        logic              event_valid;
        logic [BYTE_W-1:0] event_status;
        logic [BYTE_W-1:0] event_data1;
        logic [BYTE_W-1:0] event_data2;
        logic              last_of_run;
        logic              track_ended;
    } t_result;

endpackage

// ----- hdl/mes_channels.sv -----
// Handshake channel interfaces: command input, configuration write, result output.
interface mes_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [mes_pkg::CMD_W-1:0]     command;
    logic [mes_pkg::IDX_W-1:0]     load_index;
    logic [mes_pkg::DELTA_W-1:0]   load_delta;
    logic [mes_pkg::BYTE_W-1:0]    load_status;
    logic [mes_pkg::BYTE_W-1:0]    load_data1;
    logic [mes_pkg::BYTE_W-1:0]    load_data2;
    logic                          load_has_second;
    logic [mes_pkg::TIME_W-1:0]    time_now;

    modport source (
        output valid, command, load_index, load_delta, load_status,
               load_data1, load_data2, load_has_second, time_now,
        input  ready
    );
    modport sink (
        input  valid, command, load_index, load_delta, load_status,
               load_data1, load_data2, load_has_second, time_now,
        output ready
    );
endinterface

interface mes_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mes_pkg::CFG_IDX_W-1:0]     index;
    logic [mes_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface mes_res_if;
    logic                          valid;
    logic                          ready;
    logic                          event_valid;
    logic [mes_pkg::BYTE_W-1:0]    event_status;
    logic [mes_pkg::BYTE_W-1:0]    event_data1;
    logic [mes_pkg::BYTE_W-1:0]    event_data2;
    logic                          last_of_run;
    logic                          track_ended;

    modport source (
        output valid, event_valid, event_status, event_data1, event_data2,
               last_of_run, track_ended,
        input  ready
    );
    modport sink (
        input  valid, event_valid, event_status, event_data1, event_data2,
               last_of_run, track_ended,
        output ready
    );
endinterface

// ----- hdl/mes_result_reg.sv -----
// Output register stage that holds one result until the sink takes it.
`include "assert_macros.svh"

module mes_result_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mes_pkg::t_result i_data,
    output logic             o_free,
    mes_res_if.source        o_res
);

    logic             r_valid;
    mes_pkg::t_result r_data;

    // Free when empty or when the held result leaves this cycle.
    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_data;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.event_valid  = r_data.event_valid;
    assign o_res.event_status = r_data.event_status;
    assign o_res.event_data1  = r_data.event_data1;
    assign o_res.event_data2  = r_data.event_data2;
    assign o_res.last_of_run  = r_data.last_of_run;
    assign o_res.track_ended  = r_data.track_ended;

    `MES_ASSERT_IMP(a_push_only_when_free, i_clk, i_rst_n, i_push, o_free, "result overwritten before transfer")

endmodule

// ----- hdl/midi_event_sequencer.sv -----
// Top level of the MIDI event sequencer: event store, playback walker and ports.
//
//   channel   dir   handshake       carries
//   -------   ---   -------------   -------------------------------------------
//   i_cmd     in    valid / ready   command, load event fields, time_now
//   i_cfg     in    valid / ready   register index, write data (always ready)
//   o_res     out   valid / ready   released event bytes, last_of_run, track_ended
//
// A time query takes the command and fetches the first event, then examines
// stored events one at a time (at least one, even at the end of the track; the
// event store delivers one entry a cycle through its single read port while the
// walk is not stalled), and ends with the closing result. Stalls on o_res hold
// the walk in place while an event is held. Reset clears position, read index
// and event count and sets ticks per beat to 96; the event store is not cleared.
`include "assert_macros.svh"

module midi_event_sequencer #(
    parameter int SLOTS       = mes_pkg::DEF_SLOTS,
    parameter int EVENT_DEPTH = mes_pkg::DEF_EVENT_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mes_cmd_if.sink    i_cmd,
    mes_cfg_if.sink    i_cfg,
    mes_res_if.source  o_res
);

    localparam int AW  = $clog2(EVENT_DEPTH);
    localparam int SW  = $clog2(SLOTS + 1);
    localparam int CW  = mes_pkg::COUNT_W;
    localparam int IW  = mes_pkg::IDX_W;
    localparam int PW  = mes_pkg::POS_W;
    localparam int PW1 = PW + 1;
    localparam int LW  = mes_pkg::LIMIT_W;
    localparam int TW  = mes_pkg::TPB_W;
    localparam int FW  = mes_pkg::FRAC_W;
    localparam int BW  = mes_pkg::BYTE_W;

    // Largest count the store can hold, in the count register's width.
    localparam logic [CW-1:0] COUNT_CLAMP =
        (EVENT_DEPTH >= (1 << CW)) ? {CW{1'b1}} : CW'(EVENT_DEPTH);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

    typedef struct packed {
        logic [mes_pkg::DELTA_W-1:0] delta;
        logic [BW-1:0]               status;
        logic [BW-1:0]               data1;
        logic [BW-1:0]               data2;
        logic                        has_second;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH
    } t_state;

    // Event store: one write port (loads), one registered read port (walker).
    t_entry r_event_store [EVENT_DEPTH];
    t_entry r_rd_data;

    t_state           r_state;
    logic [TW-1:0]    r_tpb;
    logic [CW-1:0]    r_event_count;
    logic [CW-1:0]    r_read_index;
    logic [PW-1:0]    r_pos;
    logic [LW-1:0]    r_limit;
    logic [SW-1:0]    r_slot;
    logic             r_hold_valid;
    mes_pkg::t_result r_hold;

    logic             cmd_xfer;
    logic             cfg_xfer;
    logic             load_we;
    logic [IW+AW-1:0] load_ext;
    logic [AW-1:0]    load_addr;
    t_entry           load_entry;
    logic             rd_en;
    logic [CW-1:0]    rd_index;
    logic [CW+AW-1:0] rd_ext;
    logic [AW-1:0]    rd_addr;
    logic [CW-1:0]    idx_next;
    logic [CW-1:0]    live_count;
    logic             at_end;
    logic [PW1-1:0]   cum_sum;
    logic [PW-1:0]    cum;
    logic             fits;
    logic             release_ev;
    logic             is_meta;
    logic             out_free;
    logic             stall;
    logic             push;
    mes_pkg::t_result push_data;
    mes_pkg::t_result next_hold;

    // ---------------------------------------------------------------- handshakes
    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign cmd_xfer    = i_cmd.valid && i_cmd.ready;
    assign cfg_xfer    = i_cfg.valid && i_cfg.ready;

    // ---------------------------------------------------------------- store write
    // Drop loads aimed past the end of the store.
    assign load_ext  = {{AW{1'b0}}, i_cmd.load_index};
    assign load_addr = load_ext[AW-1:0];
    assign load_we   = cmd_xfer && (i_cmd.command == mes_pkg::CMD_LOAD)
                       && (32'(i_cmd.load_index) < 32'(EVENT_DEPTH));

    assign load_entry.delta      = i_cmd.load_delta;
    assign load_entry.status     = i_cmd.load_status;
    assign load_entry.data1      = i_cmd.load_data1;
    assign load_entry.data2      = i_cmd.load_data2;
    assign load_entry.has_second = i_cmd.load_has_second;

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_event_store[load_addr] <= load_entry;
        end
    end

    // ---------------------------------------------------------------- store read
    // While idle, keep the entry at the read index ready for a query. While
    // walking, fetch the next entry ahead; if the current one is not released
    // the walk stops and the early fetch is simply unused.
    assign idx_next = r_read_index + 1'b1;
    assign rd_index = (r_state == S_IDLE) ? r_read_index : idx_next;
    assign rd_ext   = {{AW{1'b0}}, rd_index};
    assign rd_addr  = rd_ext[AW-1:0];

    always_comb begin
        case (r_state)
            S_IDLE:  rd_en = 1'b1;
            S_RUN:   rd_en = !stall;
            default: rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_event_store[rd_addr];
        end
    end

    // ---------------------------------------------------------------- release test
    assign live_count = (r_event_count > COUNT_CLAMP) ? COUNT_CLAMP : r_event_count;
    assign at_end     = (r_read_index >= live_count);

    // Cumulative tick time of the current entry, saturating at the position width.
    assign cum_sum = {1'b0, r_pos} + PW1'(r_rd_data.delta);
    assign cum     = cum_sum[PW] ? {PW{1'b1}} : cum_sum[PW-1:0];
    // ticks / ticks_per_beat <= beats, cross-multiplied so the test is exact.
    assign fits    = ({cum, {FW{1'b0}}} <= {1'b0, r_limit});

    assign release_ev = !at_end && fits;
    assign is_meta    = ((r_rd_data.status & mes_pkg::META_MASK) == mes_pkg::META_MASK);

    // Hold the walk while a held event might need the busy output register.
    assign stall = r_hold_valid && !out_free;

    always_comb begin
        next_hold.event_valid  = 1'b1;
        next_hold.event_status = r_rd_data.status;
        next_hold.event_data1  = r_rd_data.data1;
        next_hold.event_data2  = r_rd_data.has_second ? r_rd_data.data2 : '0;
        next_hold.last_of_run  = 1'b0;
        // End flag of a held event is fixed when it is consumed.
        next_hold.track_ended  = (idx_next >= live_count);
    end

    // ---------------------------------------------------------------- result push
    // A channel event is held back one step so the final one can carry
    // last_of_run; earlier ones go out with the end flag clear.
    always_comb begin
        push      = 1'b0;
        push_data = r_hold;
        case (r_state)
            S_RUN: begin
                push                  = !stall && release_ev && !is_meta && r_hold_valid;
                push_data.last_of_run = 1'b0;
                push_data.track_ended = 1'b0;
            end
            S_FINISH: begin
                push = out_free;
                if (r_hold_valid) begin
                    push_data.last_of_run = 1'b1;
                end else begin
                    push_data.event_valid  = 1'b0;
                    push_data.event_status = '0;
                    push_data.event_data1  = '0;
                    push_data.event_data2  = '0;
                    push_data.last_of_run  = 1'b1;
                    push_data.track_ended  = at_end;
                end
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    mes_result_reg u_result_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_free  (out_free),
        .o_res   (o_res)
    );

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_tpb         <= mes_pkg::TPB_RESET;
            r_event_count <= '0;
            r_read_index  <= '0;
            r_pos         <= '0;
            r_slot        <= '0;
            r_hold_valid  <= 1'b0;
        end else begin
            if (cfg_xfer) begin
                case (i_cfg.index)
                    mes_pkg::REG_TICKS_PER_BEAT: r_tpb         <= i_cfg.data[TW-1:0];
                    mes_pkg::REG_EVENT_COUNT:    r_event_count <= i_cfg.data[CW-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (cmd_xfer) begin
                        case (i_cmd.command)
                            mes_pkg::CMD_QUERY: begin
                                // Time limit in ticks scaled by 2^16, fixed for the run.
                                r_limit      <= LW'(i_cmd.time_now) * LW'(r_tpb);
                                r_slot       <= '0;
                                r_hold_valid <= 1'b0;
                                r_state      <= S_RUN;
                            end
                            mes_pkg::CMD_RESTART: begin
                                r_read_index <= '0;
                                r_pos        <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RUN: begin
                    if (!stall) begin
                        if (release_ev) begin
                            r_pos        <= cum;
                            r_read_index <= idx_next;
                            r_slot       <= r_slot + 1'b1;
                            if (!is_meta) begin
                                r_hold       <= next_hold;
                                r_hold_valid <= 1'b1;
                            end
                            // Last slot used: close the run.
                            if (r_slot == LAST_SLOT) begin
                                r_state <= S_FINISH;
                            end
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_hold_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- checks
    `MES_ASSERT(a_slot_bound, i_clk, i_rst_n, r_slot <= SW'(SLOTS), "slot count beyond limit")
    `MES_ASSERT(a_pos_monotonic, i_clk, i_rst_n,
        (r_state == S_RUN) |=> (r_pos >= $past(r_pos)), "position moved back during a run")
    `MES_ASSERT(a_index_step, i_clk, i_rst_n,
        1'b1 |=> (r_read_index == $past(r_read_index)
            || r_read_index == $past(r_read_index) + 1'b1 || r_read_index == '0),
        "read index jumped")
    `MES_ASSERT_IMP(a_hold_in_run, i_clk, i_rst_n, r_hold_valid,
        (r_state == S_RUN || r_state == S_FINISH), "held event outside a query")

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the MIDI event sequencer: store loads, time queries, restarts.
`timescale 1ns / 100ps

module tb;

    // Widths taken from the shared package.
    localparam int CMD_W      = mes_pkg::CMD_W;
    localparam int IDX_W      = mes_pkg::IDX_W;
    localparam int DELTA_W    = mes_pkg::DELTA_W;
    localparam int BYTE_W     = mes_pkg::BYTE_W;
    localparam int TIME_W     = mes_pkg::TIME_W;
    localparam int TPB_W      = mes_pkg::TPB_W;
    localparam int COUNT_W    = mes_pkg::COUNT_W;
    localparam int POS_W      = mes_pkg::POS_W;
    localparam int FRAC_W     = mes_pkg::FRAC_W;
    localparam int CFG_IDX_W  = mes_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = mes_pkg::CFG_DATA_W;

    typedef mes_pkg::t_result t_result;

    // Block sizes and field extremes used throughout.
    localparam int SLOTS         = mes_pkg::DEF_SLOTS;
    localparam int EVENT_DEPTH   = mes_pkg::DEF_EVENT_DEPTH;
    localparam int FILL_DEPTH    = 96;
    localparam int SETTLE_CYCLES = SLOTS + 4;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int MAX_SHOWN     = 10;
    localparam int PHASE_ITEMS   = 26;

    localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;
    localparam logic [TIME_W-1:0]    TIME_MAX   = {TIME_W{1'b1}};
    localparam logic [TPB_W-1:0]     TPB_MAX    = {TPB_W{1'b1}};
    localparam logic [COUNT_W-1:0]   COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [IDX_W-1:0]     IDX_MAX    = {IDX_W{1'b1}};
    localparam logic [63:0]          POS_LIMIT  = 64'h0000_00FF_FFFF_FFFF;

    // One command transfer, every field driven even where the command ignores it.
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [IDX_W-1:0]   load_index;
        logic [DELTA_W-1:0] load_delta;
        logic [BYTE_W-1:0]  load_status;
        logic [BYTE_W-1:0]  load_data1;
        logic [BYTE_W-1:0]  load_data2;
        logic               load_has_second;
        logic [TIME_W-1:0]  time_now;
    } t_cmd_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mes_cmd_if cmd_ch ();
    mes_cfg_if cfg_ch ();
    mes_res_if res_ch ();

    midi_event_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // 2 ns period: high half, then low half.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the track: event store, playback cursor and registers.
    logic [DELTA_W-1:0] st_delta  [EVENT_DEPTH];
    logic [BYTE_W-1:0]  st_status [EVENT_DEPTH];
    logic [BYTE_W-1:0]  st_data1  [EVENT_DEPTH];
    logic [BYTE_W-1:0]  st_data2  [EVENT_DEPTH];
    logic               st_has2   [EVENT_DEPTH];
    int                 play_idx;
    logic [POS_W-1:0]   play_pos;
    logic [TPB_W-1:0]   cur_tpb;
    logic [COUNT_W-1:0] cur_count;

    // Released events the block still owes, oldest first.
    t_result owed_results[$];

    int failures;
    int shown;
    int sink_wait;
    bit src_idle_on;
    bit snk_idle_on;

    // ------------------------------------------------------------------
    // Playback prediction
    // ------------------------------------------------------------------

    // Walk the track for one time query and queue the results it releases.
    // Each channel event is held back one step so the closing flag lands
    // on the final one; meta and sysex events burn a slot silently.
    task automatic walk_query(input logic [TIME_W-1:0] t_now);
        logic [63:0] limit;
        logic [63:0] cum;
        int          live;
        int          n;
        int          s;
        int          e;
        t_result     held;
        limit = 64'(t_now) * 64'(cur_tpb);
        live  = (int'(cur_count) > EVENT_DEPTH) ? EVENT_DEPTH : int'(cur_count);
        n     = 0;
        held  = '0;
        for (s = 0; s < SLOTS; s++) begin
            if (play_idx >= live)
                break;
            cum = 64'(play_pos) + 64'(st_delta[play_idx]);
            if (cum > POS_LIMIT)
                cum = POS_LIMIT;
            if ((cum << FRAC_W) > limit)
                break;
            play_pos = cum[POS_W-1:0];
            e = play_idx;
            play_idx++;
            if ((st_status[e] & mes_pkg::META_MASK) == mes_pkg::META_MASK)
                continue;
            if (n > 0)
                owed_results.push_back(held);
            held.event_valid  = 1'b1;
            held.event_status = st_status[e];
            held.event_data1  = st_data1[e];
            held.event_data2  = st_has2[e] ? st_data2[e] : '0;
            held.last_of_run  = 1'b0;
            held.track_ended  = (play_idx >= live);
            n++;
        end
        if (n == 0) begin
            // Nothing released: a lone closing result with the current end flag.
            held = '0;
            held.track_ended = (play_idx >= live);
        end
        held.last_of_run = 1'b1;
        owed_results.push_back(held);
    endtask

    // Advance the shadow state by one accepted command.
    task automatic play_item(input t_cmd_item it);
        case (it.command)
            mes_pkg::CMD_LOAD: begin
                if (int'(it.load_index) < EVENT_DEPTH) begin
                    st_delta[it.load_index]  = it.load_delta;
                    st_status[it.load_index] = it.load_status;
                    st_data1[it.load_index]  = it.load_data1;
                    st_data2[it.load_index]  = it.load_data2;
                    st_has2[it.load_index]   = it.load_has_second;
                end
            end
            mes_pkg::CMD_QUERY: walk_query(it.time_now);
            mes_pkg::CMD_RESTART: begin
                play_idx = 0;
                play_pos = '0;
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Fill every field with random bits, then fix the command.
    function automatic t_cmd_item rand_item(input logic [CMD_W-1:0] cmd);
        t_cmd_item it;
        it.command         = cmd;
        it.load_index      = IDX_W'($urandom());
        it.load_delta      = DELTA_W'($urandom());
        it.load_status     = BYTE_W'($urandom());
        it.load_data1      = BYTE_W'($urandom());
        it.load_data2      = BYTE_W'($urandom());
        it.load_has_second = 1'($urandom());
        it.time_now        = TIME_W'({$urandom(), $urandom()});
        return it;
    endfunction

    // Random event for one slot; short deltas unless a wide one is asked for.
    function automatic t_cmd_item rand_load(input int idx, input bit wide_delta);
        t_cmd_item it;
        it = rand_item(mes_pkg::CMD_LOAD);
        it.load_index = IDX_W'(idx);
        if (!wide_delta)
            it.load_delta = DELTA_W'($urandom_range(0, 200));
        if ($urandom_range(0, 7) == 0)
            it.load_status[7:4] = 4'hF;
        return it;
    endfunction

    // Pick a time that lands right at, or one step short of, the release
    // point of the event k slots ahead of the cursor.
    function automatic logic [TIME_W-1:0] time_ahead(input int k);
        logic [63:0] ticks;
        logic [63:0] t;
        int          i;
        ticks = 64'(play_pos);
        for (i = 0; i < k; i++) begin
            if (play_idx + i < FILL_DEPTH)
                ticks += 64'(st_delta[play_idx + i]);
        end
        if (cur_tpb == '0)
            return TIME_W'({$urandom(), $urandom()});
        t = ((ticks << FRAC_W) + 64'(cur_tpb) - 64'd1) / 64'(cur_tpb);
        if (t > 0 && $urandom_range(0, 2) == 0)
            t = t - 1;
        if (t > 64'(TIME_MAX))
            t = 64'(TIME_MAX);
        return t[TIME_W-1:0];
    endfunction

    function automatic int src_gap();
        return src_idle_on ? $urandom_range(0, 14) : 0;
    endfunction

    // Hold valid until the block takes the transfer, then predict.
    // Valid stays high on return so a back-to-back item keeps it asserted.
    task automatic send_item(input t_cmd_item it);
        int gap;
        gap = src_gap();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid           <= 1'b1;
        cmd_ch.command         <= it.command;
        cmd_ch.load_index      <= it.load_index;
        cmd_ch.load_delta      <= it.load_delta;
        cmd_ch.load_status     <= it.load_status;
        cmd_ch.load_data1      <= it.load_data1;
        cmd_ch.load_data2      <= it.load_data2;
        cmd_ch.load_has_second <= it.load_has_second;
        cmd_ch.time_now        <= it.time_now;
        do @(posedge i_clk); while (!cmd_ch.ready);
        play_item(it);
    endtask

    task automatic load_event(input logic [IDX_W-1:0] idx, input logic [DELTA_W-1:0] delta,
                              input logic [BYTE_W-1:0] status, input logic [BYTE_W-1:0] d1,
                              input logic [BYTE_W-1:0] d2, input logic has2);
        t_cmd_item it;
        it = rand_item(mes_pkg::CMD_LOAD);
        it.load_index      = idx;
        it.load_delta      = delta;
        it.load_status     = status;
        it.load_data1      = d1;
        it.load_data2      = d2;
        it.load_has_second = has2;
        send_item(it);
    endtask

    task automatic query_at(input logic [TIME_W-1:0] t_now);
        t_cmd_item it;
        it = rand_item(mes_pkg::CMD_QUERY);
        it.time_now = t_now;
        send_item(it);
    endtask

    task automatic restart_play();
        send_item(rand_item(mes_pkg::CMD_RESTART));
    endtask

    // Register write; valid is left high so a second write follows directly.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == mes_pkg::REG_TICKS_PER_BEAT)
            cur_tpb = val[TPB_W-1:0];
        else if (idx == mes_pkg::REG_EVENT_COUNT)
            cur_count = val[COUNT_W-1:0];
    endtask

    task automatic set_regs(input logic [TPB_W-1:0] tpb, input logic [COUNT_W-1:0] cnt);
        write_reg(mes_pkg::REG_TICKS_PER_BEAT, CFG_DATA_W'(tpb));
        write_reg(mes_pkg::REG_EVENT_COUNT, CFG_DATA_W'(cnt));
        cfg_ch.valid <= 1'b0;
    endtask

    // Drop valid and hold off until every owed result is in, then let the
    // block finish any load or restart still in flight.
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: ready with random stalls, and the checker
    // ------------------------------------------------------------------

    // Draw a fresh stall after every result transfer; ready rises once it runs out.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_wait = 0;
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready)
                sink_wait = snk_idle_on ? $urandom_range(0, 14) : 0;
            else if (sink_wait > 0)
                sink_wait--;
            res_ch.ready <= (sink_wait == 0);
        end
    end

    // Compare every result transfer against the oldest owed result.
    always @(posedge i_clk) begin : check_results
        t_result seen;
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            seen.event_valid  = res_ch.event_valid;
            seen.event_status = res_ch.event_status;
            seen.event_data1  = res_ch.event_data1;
            seen.event_data2  = res_ch.event_data2;
            seen.last_of_run  = res_ch.last_of_run;
            seen.track_ended  = res_ch.track_ended;
            if (owed_results.size() == 0) begin
                failures++;
                if (shown < MAX_SHOWN) begin
                    shown++;
                    $display("[%0t] unexpected result: valid=%b status=%h d1=%h d2=%h last=%b end=%b",
                             $realtime, seen.event_valid, seen.event_status, seen.event_data1,
                             seen.event_data2, seen.last_of_run, seen.track_ended);
                end
            end else begin
                want = owed_results.pop_front();
                if (seen.event_valid  !== want.event_valid  ||
                    seen.event_status !== want.event_status ||
                    seen.event_data1  !== want.event_data1  ||
                    seen.event_data2  !== want.event_data2  ||
                    seen.last_of_run  !== want.last_of_run  ||
                    seen.track_ended  !== want.track_ended) begin
                    failures++;
                    if (shown < MAX_SHOWN) begin
                        shown++;
                        $display("[%0t] mismatch exp valid=%b status=%h d1=%h d2=%h last=%b end=%b",
                                 $realtime, want.event_valid, want.event_status, want.event_data1,
                                 want.event_data2, want.last_of_run, want.track_ended);
                        $display("[%0t]          act valid=%b status=%h d1=%h d2=%h last=%b end=%b",
                                 $realtime, seen.event_valid, seen.event_status, seen.event_data1,
                                 seen.event_data2, seen.last_of_run, seen.track_ended);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Write the first FILL_DEPTH slots of the store once, back to back. Later
    // tests keep their walks within that span, so no walk touches an unwritten entry.
    task automatic test_fill_store();
        int i;
        src_idle_on = 1'b0;
        for (i = 0; i < FILL_DEPTH; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_item(rand_load(i, 1'b1));
            else begin
                t_cmd_item it;
                it = rand_load(i, 1'b0);
                it.load_delta = DELTA_W'($urandom_range(0, 15));
                send_item(it);
            end
        end
        src_idle_on = 1'b1;
        wait_drained();
    endtask

    // Hand-built track of eight events covering meta, sysex, a missing second
    // byte, byte extremes and the widest delta.
    task automatic test_directed();
        // Empty track: one closing result with no event and the end flag set.
        query_at('0);
        // The spare command code must be dropped without a result.
        send_item(rand_item(CMD_UNUSED));
        load_event(0, '0, 8'h90, 8'h3C, 8'h7F, 1'b1);
        load_event(1, '0, 8'hFF, 8'h2F, 8'h00, 1'b1);
        load_event(2, 28'd48, 8'h80, 8'hFF, 8'hFF, 1'b0);
        load_event(3, 28'd48, 8'hF0, 8'h7E, 8'h01, 1'b1);
        load_event(4, {DELTA_W{1'b1}}, 8'hC0, 8'h00, 8'h00, 1'b0);
        load_event(5, '0, 8'hB0, 8'hFF, 8'hFF, 1'b1);
        load_event(6, 28'd1, 8'hE0, 8'h00, 8'h40, 1'b1);
        load_event(7, '0, 8'hFF, 8'h2F, 8'h00, 1'b0);
        load_event(IDX_MAX, 28'h5555555, 8'h9F, 8'hAA, 8'h55, 1'b1);
        wait_drained();
        write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
        set_regs(mes_pkg::TPB_RESET, COUNT_W'(8));
        // Time zero releases only the events at tick zero.
        query_at('0);
        // Half a beat at 96 ticks per beat sits exactly on tick 48.
        query_at(TIME_W'(40'h8000));
        // Run to the end of the track, then query past it.
        query_at(TIME_MAX);
        query_at(TIME_MAX);
        restart_play();
        wait_drained();
        // Zero ticks per beat: only tick zero passes, whatever the time.
        set_regs('0, COUNT_W'(8));
        query_at(TIME_MAX);
        wait_drained();
        set_regs(TPB_MAX, COUNT_W'(8));
        query_at(TIME_MAX);
    endtask

    // Walk under an oversized event count, which clamps at the store depth,
    // while each walk still fits inside the written span; then play the written track
    // to its end and step past it.
    task automatic test_long_track();
        int rounds;
        restart_play();
        wait_drained();
        set_regs(TPB_MAX, COUNT_MAX);
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        rounds = 0;
        while (play_idx + SLOTS <= FILL_DEPTH && rounds < 6) begin
            query_at(time_ahead($urandom_range(1, SLOTS)));
            rounds++;
        end
        wait_drained();
        set_regs(TPB_MAX, COUNT_W'(FILL_DEPTH));
        rounds = 0;
        while (play_idx < FILL_DEPTH && rounds < 20) begin
            query_at(TIME_MAX);
            rounds++;
        end
        query_at(TIME_MAX);
        query_at(TIME_MAX);
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
    endtask

    // Phases of random traffic, each under its own register setting.
    // Most queries aim at the release edge of an upcoming event.
    task automatic test_random();
        int          phase;
        int          sent;
        int          steps;
        int          pause_at;
        int          r;
        logic [TPB_W-1:0]   tpb;
        logic [COUNT_W-1:0] cnt;
        t_cmd_item   it;
        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                0:       begin tpb = mes_pkg::TPB_RESET; cnt = COUNT_W'(64);             end
                1:       begin tpb = TPB_W'(1);   cnt = COUNT_W'(FILL_DEPTH - 1);        end
                2:       begin tpb = TPB_MAX;     cnt = COUNT_W'(FILL_DEPTH);            end
                3:       begin tpb = TPB_W'(480); cnt = COUNT_W'(17);                    end
                4:       begin tpb = '0;          cnt = COUNT_W'(30);                    end
                5: begin
                    tpb = TPB_W'($urandom_range(1, int'(TPB_MAX)));
                    cnt = COUNT_W'($urandom_range(0, FILL_DEPTH));
                end
                default: begin tpb = TPB_W'(24);  cnt = COUNT_W'(1);                     end
            endcase
            wait_drained();
            src_idle_on = ($urandom_range(0, 3) != 0);
            snk_idle_on = ($urandom_range(0, 3) != 0);
            set_regs(tpb, cnt);
            restart_play();
            pause_at = $urandom_range(5, 20);
            sent  = 0;
            steps = 0;
            while (sent < PHASE_ITEMS) begin
                // Hold the sender once per phase until the block has caught up.
                if (steps == pause_at)
                    wait_drained();
                steps++;
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    query_at(time_ahead($urandom_range(0, SLOTS + 2)));
                    sent++;
                end else if (r < 60) begin
                    case ($urandom_range(0, 3))
                        0:       query_at('0);
                        1:       query_at(TIME_MAX);
                        default: query_at(TIME_W'({$urandom(), $urandom()}));
                    endcase
                    sent++;
                end else if (r < 82) begin
                    if ($urandom_range(0, 3) != 0)
                        it = rand_load((play_idx + $urandom_range(0, 24)) % FILL_DEPTH,
                                       $urandom_range(0, 9) == 0);
                    else
                        it = rand_load($urandom_range(0, FILL_DEPTH - 1),
                                       $urandom_range(0, 9) == 0);
                    send_item(it);
                    sent++;
                end else if (r < 90) begin
                    restart_play();
                    sent++;
                end else if (r < 95) begin
                    send_item(rand_item(CMD_UNUSED));
                end else begin
                    wait_drained();
                end
            end
        end
    endtask

    // Drain, settle, and report.
    task automatic finish_run();
        int waited;
        cmd_ch.valid <= 1'b0;
        waited = 0;
        while (owed_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (owed_results.size() != 0) begin
            failures += owed_results.size();
            $display("%0d expected results never arrived", owed_results.size());
        end
        if (failures == 0)
            $display("midi_event_sequencer regression: pass");
        else
            $display("midi_event_sequencer regression: fail");
        $finish;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        // Drive every input to a known value before the first edge.
        i_rst_n                <= 1'b0;
        cmd_ch.valid           <= 1'b0;
        cmd_ch.command         <= mes_pkg::CMD_LOAD;
        cmd_ch.load_index      <= '0;
        cmd_ch.load_delta      <= '0;
        cmd_ch.load_status     <= '0;
        cmd_ch.load_data1      <= '0;
        cmd_ch.load_data2      <= '0;
        cmd_ch.load_has_second <= 1'b0;
        cmd_ch.time_now        <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= mes_pkg::REG_TICKS_PER_BEAT;
        cfg_ch.data            <= '0;
        failures    = 0;
        shown       = 0;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        play_idx    = 0;
        play_pos    = '0;
        cur_tpb     = mes_pkg::TPB_RESET;
        cur_count   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_store();
        test_directed();
        test_long_track();
        test_random();
        finish_run();
    end

    // Watchdog: end a run that hangs.
    initial begin : watchdog
        #1_600_000;
        $display("midi_event_sequencer regression: fail");
        $finish;
    end

endmodule
